/* sv/fmdot_pkg.sv */
// Shared types, constants and binary32 arithmetic for the multi-row dot product.
// No dependencies; imported by fmdot_lane and the top level.
package fmdot_pkg;

   localparam int unsigned MaxRows = 8;
   localparam int unsigned RowCntW = 4;
   localparam logic [31:0] Qnan32  = 32'h7FC0_0000;
   localparam logic [31:0] PosZero = 32'h0000_0000;

   typedef struct packed {
      logic valid;
      logic last;
      logic active;
   } lane_ctl_type;

   // round (-1)^sign * sig * 2^exp to binary32, round to nearest even
   function automatic logic [31:0] round_pack(input logic sign, input int expo,
                                              input logic [57:0] sig);
      int          msb;
      int          shift;
      int          floor_shift;
      int          qexp;
      int          biased;
      logic [63:0] s64;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      msb = 0;
      s64 = {6'd0, sig};
      for (int i = 0; i < 58; i++) begin
         if (sig[i]) begin
            msb = i;
         end
      end
      shift       = msb - 23;
      floor_shift = -149 - expo;
      if (floor_shift > shift) begin
         shift = floor_shift;
      end
      if (shift <= 0) begin
         q = s64 << (-shift);
      end else if (shift > 62) begin
         q = 64'd0;
      end else begin
         rem  = s64 & ((64'd1 << shift) - 64'd1);
         half = 64'd1 << (shift - 1);
         q    = s64 >> shift;
         if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
         end
      end
      qexp = expo + shift;
      if (q == 64'd0) begin
         return {sign, 31'd0};
      end
      if (q[24]) begin
         q    = q >> 1;
         qexp = qexp + 1;
      end
      if (q < 64'h80_0000) begin
         return {sign, 8'd0, q[22:0]};
      end
      biased = qexp + 150;
      if (biased >= 255) begin
         return {sign, 31'h7F80_0000};
      end
      return {sign, biased[7:0], q[22:0]};
   endfunction

   function automatic logic is_nan32(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf32(input logic [31:0] b);
      return b[30:0] == 31'h7F80_0000;
   endfunction

   function automatic logic is_zero32(input logic [31:0] b);
      return b[30:0] == 31'd0;
   endfunction

   // binary32 times alternative half (no inf/nan in the half operand)
   function automatic logic [31:0] mul_alt(input logic [31:0] x, input logic [15:0] h);
      logic        sign;
      logic [23:0] mx;
      logic [10:0] mw;
      int          ex;
      int          ew;
      logic        h_zero;
      sign   = x[31] ^ h[15];
      h_zero = (h[14:0] == 15'd0);
      if (x[30:23] == 8'd0) begin
         mx = {1'b0, x[22:0]};
         ex = -149;
      end else begin
         mx = {1'b1, x[22:0]};
         ex = int'(x[30:23]) - 150;
      end
      if (h[14:10] == 5'd0) begin
         mw = {1'b0, h[9:0]};
         ew = -24;
      end else begin
         mw = {1'b1, h[9:0]};
         ew = int'(h[14:10]) - 25;
      end
      if (is_nan32(x)) begin
         return Qnan32;
      end
      if (is_inf32(x)) begin
         return h_zero ? Qnan32 : {sign, 31'h7F80_0000};
      end
      if (is_zero32(x) || h_zero) begin
         return {sign, 31'd0};
      end
      return round_pack(sign, ex + ew, {23'd0, 35'(mx) * 35'(mw)});
   endfunction

   function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
      logic        sa;
      logic        sb;
      logic        ts;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [23:0] tm;
      int          xa;
      int          xb;
      int          tx;
      int          d;
      logic [63:0] big;
      logic [63:0] full;
      logic [63:0] sml;
      sa = a[31];
      sb = b[31];
      if (is_nan32(a) || is_nan32(b)) return Qnan32;
      if (is_inf32(a) && is_inf32(b)) return (sa == sb) ? a : Qnan32;
      if (is_inf32(a)) return a;
      if (is_inf32(b)) return b;
      if (is_zero32(a) && is_zero32(b)) return {sa & sb, 31'd0};
      if (is_zero32(a)) return b;
      if (is_zero32(b)) return a;
      ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
      xa = (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
      mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
      xb = (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
      if (xb > xa) begin
         tm = ma; tx = xa; ts = sa;
         ma = mb; xa = xb; sa = sb;
         mb = tm; xb = tx; sb = ts;
      end
      d   = xa - xb;
      big = {8'd0, ma, 32'd0};
      if (d >= 60) begin
         sml = 64'd1;
      end else begin
         full = {8'd0, mb, 32'd0};
         sml  = full >> d;
         if ((full & ((64'd1 << d) - 64'd1)) != 64'd0) begin
            sml[0] = 1'b1;
         end
      end
      if (sa == sb) return round_pack(sa, xa - 32, big[57:0] + sml[57:0]);
      if (big > sml) return round_pack(sa, xa - 32, big[57:0] - sml[57:0]);
      if (sml > big) return round_pack(sb, xa - 32, sml[57:0] - big[57:0]);
      return PosZero;
   endfunction

endpackage

/* sv/fmdot_lane.sv */
// One row lane: registered product, then the accumulator loop.
// Depends on fmdot_pkg.
module fmdot_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  fmdot_pkg::lane_ctl_type    ctl,
   input  logic [31:0]                vector_element,
   input  logic [15:0]                weight,
   output logic [31:0]                sum_next
);
   import fmdot_pkg::*;

   logic [31:0]  prod_ff;
   logic [31:0]  prod_in;
   lane_ctl_type ctl_ff;
   logic [31:0]  acc_ff;
   logic [31:0]  acc_in;

   assign prod_in  = mul_alt(vector_element, weight);
   assign sum_next = ctl_ff.active ? add32(acc_ff, prod_ff) : PosZero;

   always_comb begin
      acc_in = acc_ff;
      if (ctl_ff.valid) begin
         acc_in = ctl_ff.last ? PosZero : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         acc_ff <= PosZero;
      end else if (advance) begin
         ctl_ff <= ctl;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end
endmodule

/* sv/fp32_fp16alt_multi_row_dot.sv */
// Top level of the multi-row fp32 x alternative-fp16 dot product.
// Depends on fmdot_pkg and fmdot_lane.
//
// Usage:
//   req_ channel: one beat per vector element. tdata carries the fp32
//   vector element and eight alternative-fp16 weights; tlast marks the
//   final element of the vector.
//   rsp_ channel: one beat per vector, carrying eight fp32 row sums.
//   csr_: write rows_in_use (1..8; 0 counts as 1, larger as 8) while idle.
// Path: a last element passes the input, lane and result registers to rsp_.
// Throughput: one element per cycle while rsp_ does not stall; the rate is set
//   by the combinational floating-point add in each row accumulator loop.
// Reset: accumulators return to +0, rows_in_use to 8, pipeline empties.
// Stall: while a result waits and rsp_tready is low, the whole pipeline
//   holds and req_tready drops; it advances again in the cycle the result
//   is taken.
module fp32_fp16alt_multi_row_dot (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // vector_element[31:0], weight_row_0 .. weight_row_7 (16 bits each)
   input  logic [159:0]  req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // sum_row_0 .. sum_row_7 (32 bits each)
   output logic [255:0]  rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [fmdot_pkg::RowCntW-1:0] csr_wr_data
);
   import fmdot_pkg::*;

   logic [RowCntW-1:0] rows_ff;
   logic [RowCntW-1:0] rows_eff;
   logic               advance;
   logic               in_valid_ff;
   logic               in_last_ff;
   logic [MaxRows-1:0] in_active_ff;
   logic [159:0]       in_data_ff;
   logic               sum_valid_ff;
   logic               sum_last_ff;
   logic               rsp_valid_ff;
   logic [255:0]       rsp_data_ff;
   logic [255:0]       sums;

   // advance everything unless a result waits unclaimed
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      rows_eff = rows_ff;
      if (rows_ff == '0) rows_eff = RowCntW'(1);
      if (rows_ff > RowCntW'(MaxRows)) rows_eff = RowCntW'(MaxRows);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RowCntW'(MaxRows);
      end else if (csr_wr_en) begin
         rows_ff <= csr_wr_data;
      end
   end

   // input register and the valid pipeline behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
         sum_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_tvalid;
         sum_valid_ff <= in_valid_ff;
         sum_last_ff  <= in_last_ff;
         rsp_valid_ff <= sum_valid_ff && sum_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
         for (int r = 0; r < MaxRows; r++) begin
            in_active_ff[r] <= RowCntW'(r) < rows_eff;
         end
         // capture the row sums on the last element
         if (sum_valid_ff && sum_last_ff) begin
            rsp_data_ff <= sums;
         end
      end
   end

   for (genvar g = 0; g < MaxRows; g++) begin : g_lane
      lane_ctl_type ctl;
      assign ctl = '{valid: in_valid_ff, last: in_last_ff, active: in_active_ff[g]};
      fmdot_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .ctl            (ctl),
         .vector_element (in_data_ff[31:0]),
         .weight         (in_data_ff[32 + 16*g +: 16]),
         .sum_next       (sums[32*g +: 32])
      );
   end
endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for fp32_fp16alt_multi_row_dot: directed beats, then random vectors.
// Uses fmdot_pkg for the row-count width and float constants; predicts sums itself.
module tb_top;
   import fmdot_pkg::*;

   typedef struct {
      logic [31:0]       x;
      logic [7:0][15:0]  w;
      logic              last;
      bit                typed;
      logic [31:0]       typed_sum;
   } dir_row_type;

   typedef struct {
      logic [7:0][31:0] sums;
   } row_sums_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // vector_element[31:0], weight_row_0 .. weight_row_7 (16 bits each)
   logic [159:0]        req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // sum_row_0 .. sum_row_7 (32 bits each)
   logic [255:0]        rsp_tdata;
   logic                csr_wr_en;
   logic [RowCntW-1:0]  csr_wr_data;

   // predictor state: fp32 partial sums and the written row count
   logic [31:0]         acc_row [8];
   logic [RowCntW-1:0]  rows_cfg;
   row_sums_type        sums_due [$];
   dir_row_type         dir_tab [$];
   int                  errors;
   int                  beats_sent;
   int                  sums_seen;
   int                  cfg_writes;
   bit                  quiet;
   int                  hold_req;

   fp32_fp16alt_multi_row_dot uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // binary32 arithmetic of the predictor
   // ---------------------------------------------------------------
   function automatic bit f_nan(input logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 23'd0;
   endfunction

   function automatic bit f_inf(input logic [31:0] v);
      return v[30:0] == 31'h7F80_0000;
   endfunction

   function automatic bit f_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   // value is (-1)^s * m * 2^e with m below 2^60; round to nearest even
   function automatic logic [31:0] fp_pack(input bit s, input int e, input logic [63:0] m);
      int          top;
      int          sh;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] hf;
      top = 0;
      for (int i = 0; i < 64; i++) begin
         if (m[i]) top = i;
      end
      sh = top - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh <= 0) begin
         q = m << (-sh);
      end else if (sh > 62) begin
         q = 64'd0;
      end else begin
         q  = m >> sh;
         r  = m & ((64'd1 << sh) - 64'd1);
         hf = 64'd1 << (sh - 1);
         if (r > hf || (r == hf && q[0])) q = q + 64'd1;
      end
      e = e + sh;
      if (q == 64'd0) return {s, 31'd0};
      if (q[24]) begin
         q = q >> 1;
         e = e + 1;
      end
      if (q < 64'h80_0000) return {s, 8'd0, q[22:0]};
      if (e + 150 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(e + 150), q[22:0]};
   endfunction

   function automatic void fp_split(input logic [31:0] v, output logic [23:0] m,
                                    output int e);
      if (v[30:23] == 8'd0) begin
         m = {1'b0, v[22:0]};
         e = -149;
      end else begin
         m = {1'b1, v[22:0]};
         e = int'(v[30:23]) - 150;
      end
   endfunction

   // alternative half: exponent 31 is an ordinary exponent
   function automatic logic [31:0] widen_weight(input logic [15:0] h);
      if (h[14:0] == 15'd0) return {h[15], 31'd0};
      if (h[14:10] == 5'd0) return fp_pack(h[15], -24, {54'd0, h[9:0]});
      return fp_pack(h[15], int'(h[14:10]) - 25, {53'd0, 1'b1, h[9:0]});
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      bit          s;
      logic [23:0] ma;
      logic [23:0] mb;
      int          ea;
      int          eb;
      s = a[31] ^ b[31];
      if (f_nan(a) || f_nan(b)) return Qnan32;
      if (f_inf(a) || f_inf(b)) begin
         if (f_zero(a) || f_zero(b)) return Qnan32;
         return {s, 8'hFF, 23'd0};
      end
      if (f_zero(a) || f_zero(b)) return {s, 31'd0};
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      return fp_pack(s, ea + eb, {40'd0, ma} * {40'd0, mb});
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      bit          sa;
      bit          sb;
      bit          st;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [23:0] mt;
      int          ea;
      int          eb;
      int          et;
      int          d;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] full;
      sa = a[31];
      sb = b[31];
      if (f_nan(a) || f_nan(b)) return Qnan32;
      if (f_inf(a) && f_inf(b)) return (sa == sb) ? a : Qnan32;
      if (f_inf(a)) return a;
      if (f_inf(b)) return b;
      if (f_zero(a) && f_zero(b)) return {sa & sb, 31'd0};
      if (f_zero(a)) return b;
      if (f_zero(b)) return a;
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      if (eb > ea) begin
         mt = ma; et = ea; st = sa;
         ma = mb; ea = eb; sa = sb;
         mb = mt; eb = et; sb = st;
      end
      d  = ea - eb;
      hi = {8'd0, ma, 32'd0};
      if (d >= 60) begin
         lo = 64'd1;
      end else begin
         full = {8'd0, mb, 32'd0};
         lo   = full >> d;
         if ((lo << d) != full) lo[0] = 1'b1;
      end
      if (sa == sb) return fp_pack(sa, ea - 32, hi + lo);
      if (hi > lo) return fp_pack(sa, ea - 32, hi - lo);
      if (lo > hi) return fp_pack(sb, ea - 32, lo - hi);
      return PosZero;
   endfunction

   // fold one element into the row sums; true when the vector closes
   function automatic bit fold_element(input logic [31:0] x, input logic [7:0][15:0] w,
                                       input logic last, output row_sums_type res);
      int active;
      active = int'(rows_cfg);
      if (active < 1) active = 1;
      if (active > MaxRows) active = MaxRows;
      for (int k = 0; k < 8; k++) begin
         if (k < active) acc_row[k] = fp_add(acc_row[k], fp_mul(x, widen_weight(w[k])));
         else acc_row[k] = PosZero;
      end
      if (!last) return 1'b0;
      for (int k = 0; k < 8; k++) begin
         res.sums[k] = acc_row[k];
         acc_row[k]  = PosZero;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [31:0] pick_f32();
      int c;
      c = $urandom_range(0, 99);
      if (c < 60) return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
      if (c < 72) return $urandom;
      if (c < 76) return {1'($urandom), 31'd0};
      if (c < 80) return {1'($urandom), 8'hFF, 23'd0};
      if (c < 83) return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      if (c < 90) return {1'($urandom), 8'd0, 23'($urandom)};
      if (c < 95) return {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
      return {1'($urandom), 8'($urandom_range(220, 254)), 23'($urandom)};
   endfunction

   function automatic logic [15:0] pick_alt16();
      int c;
      c = $urandom_range(0, 19);
      if (c == 0) return {1'($urandom), 15'd0};
      if (c == 1) return {1'($urandom), 5'd0, 10'($urandom)};
      if (c == 2) return {1'($urandom), 5'd31, 10'($urandom)};
      return 16'($urandom);
   endfunction

   function automatic dir_row_type mk_row(input logic [31:0] x, input logic [15:0] w,
                                          input bit spread, input logic last,
                                          input bit typed, input logic [31:0] val);
      dir_row_type r;
      r.x = x;
      for (int k = 0; k < 8; k++) r.w[k] = spread ? w ^ 16'(k * 16'h1235) : w;
      r.last      = last;
      r.typed     = typed;
      r.typed_sum = val;
      return r;
   endfunction

   // offer one beat until taken, then fold it into the predictor
   task automatic send_beat(input logic [31:0] x, input logic [7:0][15:0] w,
                            input logic last, input bit typed, input logic [31:0] val);
      row_sums_type res;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (fold_element(x, w, last, res)) begin
         if (typed) res.sums = {8{val}};
         sums_due.push_back(res);
      end
   endtask

   // wait for every due sum, let the pipeline drain, then write rows_in_use
   task automatic write_rows(input logic [RowCntW-1:0] v);
      req_tvalid <= 1'b0;
      wait (sums_due.size() == 0);
      repeat (6) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      rows_cfg = v;
      cfg_writes++;
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // result side: check each taken beat, stall in random bursts
   // ---------------------------------------------------------------
   initial begin
      row_sums_type exp_s;
      int           stall_left;
      int           hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sums_seen++;
            if (sums_due.size() == 0) begin
               $error("result beat with no sums due: %h", rsp_tdata);
               errors++;
            end else begin
               exp_s = sums_due.pop_front();
               for (int k = 0; k < 8; k++) begin
                  if (rsp_tdata[32*k +: 32] !== exp_s.sums[k]) begin
                     $error("sum_row_%0d expected %h got %h", k, exp_s.sums[k],
                            rsp_tdata[32*k +: 32]);
                     errors++;
                  end
               end
            end
         end
         // a long hold-off lets the pipeline fill and back-pressure the sender
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // sender: reset, directed table, random vectors across row counts
   // ---------------------------------------------------------------
   initial begin
      logic [RowCntW-1:0] plan [12];
      logic [7:0][15:0]   wv;
      int                 n;
      int                 len;
      errors      = 0;
      beats_sent  = 0;
      sums_seen   = 0;
      cfg_writes  = 0;
      quiet       = 1'b0;
      hold_req    = 0;
      rows_cfg    = 4'd8;
      for (int k = 0; k < 8; k++) acc_row[k] = PosZero;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one- and two-beat vectors with sums read off directly, then mixed rows
      dir_tab.push_back(mk_row(32'h3F80_0000, 16'h3C00, 0, 1, 1, 32'h3F80_0000));
      dir_tab.push_back(mk_row(32'h8000_0000, 16'h3C00, 0, 1, 1, PosZero));
      dir_tab.push_back(mk_row(32'h7F80_0000, 16'h0000, 0, 1, 1, Qnan32));
      dir_tab.push_back(mk_row(32'h7F80_0001, 16'h3C00, 0, 1, 1, Qnan32));
      dir_tab.push_back(mk_row(32'h7F80_0000, 16'h3C00, 0, 1, 1, 32'h7F80_0000));
      dir_tab.push_back(mk_row(32'h7F7F_FFFF, 16'h7FFF, 0, 1, 1, 32'h7F80_0000));
      dir_tab.push_back(mk_row(32'h7F7F_FFFF, 16'hFFFF, 0, 1, 1, 32'hFF80_0000));
      dir_tab.push_back(mk_row(32'h0000_0001, 16'h3C00, 0, 1, 1, 32'h0000_0001));
      dir_tab.push_back(mk_row(32'hFFFF_FFFF, 16'h3C00, 0, 1, 1, Qnan32));
      dir_tab.push_back(mk_row(32'h7F80_0000, 16'h3C00, 0, 0, 0, 0));
      dir_tab.push_back(mk_row(32'h7F80_0000, 16'hBC00, 0, 1, 1, Qnan32));
      dir_tab.push_back(mk_row(32'h3F80_0000, 16'h3C00, 0, 0, 0, 0));
      dir_tab.push_back(mk_row(32'h3F80_0000, 16'hBC00, 0, 1, 1, PosZero));
      dir_tab.push_back(mk_row(32'h3FC0_0000, 16'h0001, 1, 0, 0, 0));
      dir_tab.push_back(mk_row(32'hC2F6_E979, 16'h8000, 1, 0, 0, 0));
      dir_tab.push_back(mk_row(32'h0040_0000, 16'h03FF, 1, 0, 0, 0));
      dir_tab.push_back(mk_row(32'h4B80_0001, 16'h7C00, 1, 1, 0, 0));
      dir_tab.push_back(mk_row(32'h0000_0000, 16'h0000, 0, 1, 0, 0));
      dir_tab.push_back(mk_row(32'hFFFF_FFFF, 16'hFFFF, 1, 1, 0, 0));
      foreach (dir_tab[i]) begin
         send_beat(dir_tab[i].x, dir_tab[i].w, dir_tab[i].last, dir_tab[i].typed,
                   dir_tab[i].typed_sum);
      end

      // row counts: extremes, the clamped codes and some in between
      plan = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd5, 4'd2, 4'd7, 4'd12, 4'd4, 4'd3, 4'd6, 4'd8};
      for (int p = 0; p < 12; p++) begin
         write_rows(plan[p]);
         if (p == 11) quiet = 1'b1;
         if (p == 3) hold_req = 300;
         n = 0;
         while (n < 150) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
               for (int k = 0; k < 8; k++) wv[k] = pick_alt16();
               send_beat(pick_f32(), wv, j == len - 1, 0, 0);
               n++;
            end
            // once, hold the sender until every due sum has come back
            if (p == 5 && n > 70 && n <= 70 + len) begin
               req_tvalid <= 1'b0;
               wait (sums_due.size() == 0);
               @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
      wait (sums_due.size() == 0);
      repeat (10) @(posedge clock);

      $display("covered %0d element beats, %0d row-sum beats, %0d row-count writes",
               beats_sent, sums_seen, cfg_writes);
      $display("row counts 0..15 incl. clamps, specials, subnormals, back-pressure");
      if (errors == 0) begin
         $display("fp32_fp16alt_multi_row_dot regression: pass");
      end else begin
         $display("fp32_fp16alt_multi_row_dot regression: fail");
      end
      $finish;
   end

   // drop the run if it hangs
   initial begin
      #4000000;
      $display("fp32_fp16alt_multi_row_dot regression: fail");
      $finish;
   end

endmodule

/* fp32_fp16alt_multi_row_dot.f */
sv/fmdot_pkg.sv
sv/fmdot_lane.sv
sv/fp32_fp16alt_multi_row_dot.sv
tb/sv/tb_top.sv
